### rtl/minifloat_to_binary64_assert.svh
// Assertion macros used by the checker file.
`ifndef MINIFLOAT_TO_BINARY64_ASSERT_SVH
`define MINIFLOAT_TO_BINARY64_ASSERT_SVH
// Same-cycle implication.
`define MFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define MFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/mfb_pkg.sv
package mfb_pkg;

  localparam int unsigned MAX_EXP_WIDTH  = 11;
  localparam int unsigned MAX_FRAC_WIDTH = 52;

  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP64_ALL_ONES = 11'h7FF;

  localparam logic REG_EXP_BITS  = 1'b0;
  localparam logic REG_MANT_BITS = 1'b1;

  typedef enum logic [2:0] {
    CLS_NORMAL    = 3'd0,
    CLS_SUBNORMAL = 3'd1,
    CLS_ZERO      = 3'd2,
    CLS_INF       = 3'd3,
    CLS_NAN       = 3'd4
  } class_e;

  // after field split
  typedef struct packed {
    logic [51:0] frac;
    logic [11:0] hi;   // exponent and sign, right-aligned
  } split_t;

  // after classification
  typedef struct packed {
    class_e      cls;
    logic        sign;
    logic [10:0] ef;
    logic [51:0] frac;
    logic [5:0]  lead;
  } clsfy_t;

  function automatic logic [3:0] clamp_ew(input logic [3:0] v);
    if (v < 4'd2) return 4'd2;
    if (v > 4'(MAX_EXP_WIDTH)) return 4'(MAX_EXP_WIDTH);
    return v;
  endfunction

  function automatic logic [5:0] clamp_fw(input logic [5:0] v);
    if (v < 6'd1) return 6'd1;
    if (v > 6'(MAX_FRAC_WIDTH)) return 6'(MAX_FRAC_WIDTH);
    return v;
  endfunction

endpackage

### rtl/mfb_if.sv
interface mfb_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_bits;
  modport source (output valid, output raw_bits, input ready);
  modport sink (input valid, input raw_bits, output ready);
endinterface

interface mfb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic [2:0]  value_class;
  logic        sign_bit;
  modport source (output valid, output value_bits, output value_class, output sign_bit,
                  input ready);
  modport sink (input valid, input value_bits, input value_class, input sign_bit,
                output ready);
endinterface

### rtl/minifloat_to_binary64.sv
// Converts packed floating-point words of a programmable format to binary64.
// Input channel in_i carries raw_bits: sign, exp_bits exponent bits and
// mant_bits fraction bits, right-aligned. Output channel out_o carries the
// binary64 pattern, the class code and the source sign.
// Format registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 exp_bits, index 1 mant_bits). The user must write them only
// while no transaction is in flight; the block does not enforce this.
// Each transaction passes the split, classify and assemble register stages.
// Throughput: one transaction per cycle; the three stages advance together.
// Reset clears all stage valid bits and loads exp_bits 8, mant_bits 23.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; nothing is lost or repeated.
module minifloat_to_binary64 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [5:0]    cfg_data_i,
  mfb_in_if.sink        in_i,
  mfb_out_if.source     out_o
);
  logic [3:0]        exp_bits_q;
  logic [5:0]        mant_bits_q;
  logic [3:0]        ew;
  logic [5:0]        fw;
  logic              en;
  logic              v1, v2;
  mfb_pkg::split_t   s1;
  mfb_pkg::clsfy_t   s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bits_q  <= 4'd8;
      mant_bits_q <= 6'd23;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mfb_pkg::REG_EXP_BITS) exp_bits_q <= cfg_data_i[3:0];
      if (cfg_idx_i == mfb_pkg::REG_MANT_BITS) mant_bits_q <= cfg_data_i;
    end
  end

  assign ew = mfb_pkg::clamp_ew(exp_bits_q);
  assign fw = mfb_pkg::clamp_fw(mant_bits_q);

  // advance when the output slot is empty or being drained
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  mfb_split u_split (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .raw_i(in_i.raw_bits),
    .fw_i(fw), .valid_o(v1), .data_o(s1)
  );

  mfb_classify u_classify (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .data_i(s1), .ew_i(ew),
    .valid_o(v2), .data_o(s2)
  );

  mfb_assemble u_assemble (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .data_i(s2), .ew_i(ew), .fw_i(fw),
    .valid_o(out_o.valid), .bits_o(out_o.value_bits), .cls_o(out_o.value_class),
    .sign_o(out_o.sign_bit)
  );
endmodule

### rtl/mfb_split.sv
module mfb_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         raw_i,
  input  logic [5:0]          fw_i,
  output logic                valid_o,
  output mfb_pkg::split_t     data_o
);
  logic              valid_q;
  mfb_pkg::split_t   data_d, data_q;
  logic [63:0]       shifted;

  always_comb begin
    shifted     = raw_i >> fw_i;
    data_d.frac = raw_i[51:0] & ({52{1'b1}} >> (6'd52 - fw_i));
    data_d.hi   = shifted[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/mfb_classify.sv
module mfb_classify (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mfb_pkg::split_t     data_i,
  input  logic [3:0]          ew_i,
  output logic                valid_o,
  output mfb_pkg::clsfy_t     data_o
);
  logic              valid_q;
  mfb_pkg::clsfy_t   data_d, data_q;
  logic [10:0]       emask;

  always_comb begin
    emask       = mfb_pkg::EXP64_ALL_ONES >> (4'd11 - ew_i);
    data_d.ef   = data_i.hi[10:0] & emask;
    data_d.sign = data_i.hi[ew_i];
    data_d.frac = data_i.frac;
    // leading one of the fraction
    data_d.lead = '0;
    for (int k = 0; k < 52; k++) begin
      if (data_i.frac[k]) data_d.lead = 6'(k);
    end
    if (data_d.ef == emask) begin
      data_d.cls = (data_i.frac == '0) ? mfb_pkg::CLS_INF : mfb_pkg::CLS_NAN;
    end else if (data_d.ef == '0) begin
      data_d.cls = (data_i.frac == '0) ? mfb_pkg::CLS_ZERO : mfb_pkg::CLS_SUBNORMAL;
    end else begin
      data_d.cls = mfb_pkg::CLS_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/mfb_assemble.sv
module mfb_assemble (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mfb_pkg::clsfy_t     data_i,
  input  logic [3:0]          ew_i,
  input  logic [5:0]          fw_i,
  output logic                valid_o,
  output logic [63:0]         bits_o,
  output logic [2:0]          cls_o,
  output logic                sign_o
);
  logic        valid_q;
  logic [63:0] bits_d, bits_q;
  logic [2:0]  cls_q;
  logic        sign_q;
  logic [9:0]  bias;
  logic [11:0] num, den, sh;
  logic [63:0] frac_ext, shl;
  logic [5:0]  amt;

  always_comb begin
    bias     = 10'h3FF >> (4'd11 - ew_i);
    frac_ext = {12'b0, data_i.frac};
    num      = 12'(data_i.lead) + 12'd1024;
    den      = 12'(fw_i) + 12'(bias);
    sh       = 12'd1075 - den;
    // one shared left shifter picks its amount by class
    if (data_i.cls == mfb_pkg::CLS_NORMAL) begin
      amt = 6'd52 - fw_i;
    end else if (num > den) begin
      amt = 6'd52 - data_i.lead;
    end else begin
      amt = sh[5:0];
    end
    shl = frac_ext << amt;
    case (data_i.cls)
      mfb_pkg::CLS_NORMAL: begin
        bits_d = {data_i.sign, 11'({1'b0, data_i.ef} + 12'd1023 - 12'(bias)), shl[51:0]};
      end
      mfb_pkg::CLS_SUBNORMAL: begin
        if (num > den) begin
          bits_d = {data_i.sign, 11'(num - den), shl[51:0]};
        end else if (sh < 12'd64) begin
          bits_d = {data_i.sign, 11'b0, shl[51:0]};
        end else begin
          bits_d = {data_i.sign, 63'b0};
        end
      end
      mfb_pkg::CLS_ZERO: bits_d = {data_i.sign, 63'b0};
      mfb_pkg::CLS_INF:  bits_d = {data_i.sign, mfb_pkg::EXP64_ALL_ONES, 52'b0};
      default:           bits_d = mfb_pkg::QNAN64;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bits_q <= bits_d;
      cls_q  <= data_i.cls;
      sign_q <= data_i.sign;
    end
  end

  assign valid_o = valid_q;
  assign bits_o  = bits_q;
  assign cls_o   = cls_q;
  assign sign_o  = sign_q;
endmodule

### rtl/mfb_checker.sv
`include "minifloat_to_binary64_assert.svh"

module mfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value_bits,
  input logic [2:0]  value_class,
  input logic        sign_bit
);
  `MFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value_bits))
  `MFB_ASSERT_NOW(a_nan_canon, out_valid && value_class == mfb_pkg::CLS_NAN, value_bits == mfb_pkg::QNAN64)
  `MFB_ASSERT_NOW(a_zero_bits, out_valid && value_class == mfb_pkg::CLS_ZERO, value_bits[62:0] == 63'b0)
  `MFB_ASSERT_NOW(a_sign_kept, out_valid && value_class != mfb_pkg::CLS_NAN, value_bits[63] == sign_bit)
  `MFB_ASSERT_NOW(a_class_range, out_valid, value_class <= mfb_pkg::CLS_NAN)
endmodule

bind minifloat_to_binary64 mfb_checker u_mfb_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .value_bits(out_o.value_bits),
  .value_class(out_o.value_class),
  .sign_bit(out_o.sign_bit)
);
